[rtl/core/ootx_dfr_pkg.sv]
package ootx_dfr_pkg;

  localparam int unsigned PULSE_W   = 32;
  localparam int unsigned STEP_W    = $clog2(PULSE_W);
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned CNT5_W    = 5;
  localparam int unsigned M_TDATA_W = 16;

  localparam logic [CNT5_W-1:0] SYNC_PERIOD    = 5'd17;
  localparam logic [CNT5_W-1:0] BC_MAX         = 5'd31;
  localparam logic [CNT5_W-1:0] BC_AFTER_START = 5'd16;

  localparam logic [LEN_W-1:0]  LEN_START  = 16'h0080;
  localparam logic [LEN_W-1:0]  LEN_WRAP   = 16'h8000;
  localparam logic [BYTE_W-1:0] BYTE_START = 8'h80;

  localparam logic REG_PULSE_MIN  = 1'b0;
  localparam logic REG_BIT_WINDOW = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_SHOW
  } seq_state_t;

  typedef struct packed {
    logic done;
    logic qbit;
  } div_stat_t;

  typedef struct packed {
    logic clear;
    logic apply;
    logic sbit;
  } frame_ctl_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } buf_wr_t;

endpackage

[rtl/core/ootx_dfr_div.sv]
module ootx_dfr_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [ootx_dfr_pkg::PULSE_W-1:0]      dividend,
  input  logic [ootx_dfr_pkg::PULSE_W-1:0]      divisor,
  output ootx_dfr_pkg::div_stat_t               stat
);
  import ootx_dfr_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PULSE_W - 1);

  logic                busy;
  logic                done;
  logic [STEP_W-1:0]   step;
  logic [PULSE_W-1:0]  rem;
  logic [PULSE_W-1:0]  dq;
  logic [PULSE_W:0]    rem_sh;
  logic [PULSE_W:0]    diff;
  logic                ge;

  always_comb begin
    rem_sh = {rem, dq[PULSE_W-1]};
    diff   = rem_sh - {1'b0, divisor};
    ge     = (rem_sh >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[PULSE_W-1:0] : rem_sh[PULSE_W-1:0];
      dq  <= {dq[PULSE_W-2:0], ge};
    end
  end

  assign stat.done = done;
  assign stat.qbit = dq[0];

endmodule

[rtl/core/ootx_dfr_frame.sv]
module ootx_dfr_frame #(
  parameter int unsigned INFO_BLOCK_BYTES = 33
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ootx_dfr_pkg::frame_ctl_t  ctl,
  output ootx_dfr_pkg::buf_wr_t     wr,
  output logic                      emit,
  output logic                      block_done
);
  import ootx_dfr_pkg::*;

  localparam int unsigned BPW = $clog2(INFO_BLOCK_BYTES + 1);
  localparam logic [BPW-1:0]   BP_FULL   = BPW'(INFO_BLOCK_BYTES);
  localparam logic [LEN_W-1:0] LEN_MATCH = LEN_W'(INFO_BLOCK_BYTES);

  logic [CNT5_W-1:0] zero_run, zero_run_next;
  logic [CNT5_W-1:0] bit_count, bit_count_next;
  logic [LEN_W-1:0]  length_mask, length_mask_next;
  logic [LEN_W-1:0]  length_value, length_value_next;
  logic [BYTE_W-1:0] byte_mask, byte_mask_next;
  logic [BYTE_W-1:0] byte_acc, byte_acc_next;
  logic [BPW-1:0]    byte_pos, byte_pos_next;
  logic              block_done_next;

  logic [CNT5_W-1:0] bc_inc;
  logic [CNT5_W-1:0] zr_inc;
  logic [LEN_W-1:0]  lm_shift;
  logic [BYTE_W-1:0] bm_shift;
  logic [BPW-1:0]    bp_inc;
  logic              run_data;

  assign bc_inc   = (bit_count < BC_MAX) ? bit_count + CNT5_W'(1) : bit_count;
  assign zr_inc   = zero_run + CNT5_W'(1);
  assign lm_shift = length_mask >> 1;
  assign bm_shift = byte_mask >> 1;
  assign bp_inc   = byte_pos + BPW'(1);

  always_comb begin
    zero_run_next     = zero_run;
    bit_count_next    = bit_count;
    length_mask_next  = length_mask;
    length_value_next = length_value;
    byte_mask_next    = byte_mask;
    byte_acc_next     = byte_acc;
    byte_pos_next     = byte_pos;
    block_done_next   = block_done;
    wr                = '0;
    emit              = 1'b0;
    run_data          = 1'b0;

    if (ctl.clear) begin
      byte_mask_next   = '0;
      zero_run_next    = '0;
      bit_count_next   = '0;
      length_mask_next = '0;
    end else if (ctl.apply && !block_done) begin
      if (!ctl.sbit) begin
        if (zr_inc == SYNC_PERIOD) begin
          byte_mask_next   = '0;
          zero_run_next    = '0;
          bit_count_next   = BC_AFTER_START;
          length_mask_next = LEN_START;
        end else if (bc_inc == SYNC_PERIOD && (length_mask != '0 || byte_mask != '0)) begin
          byte_mask_next   = '0;
          zero_run_next    = '0;
          bit_count_next   = '0;
          length_mask_next = '0;
        end else begin
          zero_run_next  = zr_inc;
          bit_count_next = bc_inc;
          run_data       = 1'b1;
        end
      end else begin
        zero_run_next = '0;
        if (bc_inc == SYNC_PERIOD) begin
          bit_count_next = '0;
          if (byte_pos == BP_FULL) begin
            byte_pos_next   = '0;
            block_done_next = 1'b1;
            emit            = 1'b1;
          end
        end else begin
          bit_count_next = bc_inc;
          run_data       = 1'b1;
        end
      end

      if (run_data) begin
        if (length_mask != '0) begin
          length_value_next = ctl.sbit ? (length_value | length_mask)
                                       : (length_value & ~length_mask);
          if (lm_shift == '0) begin
            length_mask_next = LEN_WRAP;
          end else if (lm_shift == LEN_START) begin
            length_mask_next = '0;
            if (length_value_next == LEN_MATCH) begin
              byte_pos_next  = '0;
              byte_mask_next = BYTE_START;
            end
          end else begin
            length_mask_next = lm_shift;
          end
        end else if (byte_mask != '0) begin
          byte_acc_next  = {byte_acc[BYTE_W-2:0], ctl.sbit};
          byte_mask_next = bm_shift;
          if (bm_shift == '0) begin
            wr.we         = 1'b1;
            wr.addr       = IDX_W'(byte_pos);
            wr.data       = byte_acc_next;
            byte_pos_next = bp_inc;
            if (bp_inc < BP_FULL) begin
              byte_mask_next = BYTE_START;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run     <= '0;
      bit_count    <= '0;
      length_mask  <= '0;
      length_value <= '0;
      byte_mask    <= '0;
      byte_pos     <= '0;
      block_done   <= 1'b0;
    end else begin
      zero_run     <= zero_run_next;
      bit_count    <= bit_count_next;
      length_mask  <= length_mask_next;
      length_value <= length_value_next;
      byte_mask    <= byte_mask_next;
      byte_pos     <= byte_pos_next;
      block_done   <= block_done_next;
    end
  end

  always_ff @(posedge clk) begin
    byte_acc <= byte_acc_next;
  end

endmodule

[rtl/core/ootx_dfr_ram.sv]
module ootx_dfr_ram #(
  parameter  int unsigned DEPTH = 33,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                                 clk,
  input  ootx_dfr_pkg::buf_wr_t                wr,
  input  logic                                 rd_en,
  input  logic [AW-1:0]                        rd_addr,
  output logic [ootx_dfr_pkg::BYTE_W-1:0]      rdata
);
  import ootx_dfr_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/ootx_info_block_deframer.sv]
// Slices one data bit per sync-pulse width and reassembles the OOTX info block.
// Each pulse transaction runs a restoring divider that retires one quotient bit per
// cycle; a pulse goes through the load, 32 divide steps and the frame update, and
// no new pulse is accepted before it is through. A restart transaction only clears
// the framer's sync state. Once a complete block of INFO_BLOCK_BYTES bytes has been
// framed, the bytes leave as one burst, each read from the buffer and then output
// until taken, with tlast on the final byte; after that the block ignores pulses
// until reset. The CRC is not checked.
module ootx_info_block_deframer #(
  parameter int unsigned INFO_BLOCK_BYTES = 33
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] pulse_ticks
  input  logic [0:0]  s_tuser,   // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [5:0] byte_index, [13:6] byte_value, [15:14] zero
  output logic        m_tlast
);
  import ootx_dfr_pkg::*;

  localparam int unsigned AW = (INFO_BLOCK_BYTES > 1) ? $clog2(INFO_BLOCK_BYTES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(INFO_BLOCK_BYTES - 1);

  seq_state_t state, state_next;

  logic [PULSE_W-1:0] pulse_min_ticks;
  logic [PULSE_W-1:0] bit_window_ticks;
  logic [IDX_W-1:0]   idx;
  logic [BYTE_W-1:0]  rdata;

  logic       s_acc;
  logic       m_acc;
  logic       div_start;
  logic       rd_en;
  logic       emit;
  logic       block_done;
  div_stat_t  div_stat;
  frame_ctl_t frame_ctl;
  buf_wr_t    buf_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_min_ticks  <= '0;
      bit_window_ticks <= PULSE_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index[0])
        REG_PULSE_MIN:  pulse_min_ticks  <= cfg_data;
        REG_BIT_WINDOW: bit_window_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_acc     = s_tvalid && s_tready;
  assign m_acc     = m_tvalid && m_tready;
  assign div_start = s_acc && !s_tuser[0] && !block_done;

  assign frame_ctl.clear = s_acc && s_tuser[0];
  assign frame_ctl.apply = (state == ST_DIV) && div_stat.done;
  assign frame_ctl.sbit  = div_stat.qbit;

  ootx_dfr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (s_tdata - pulse_min_ticks),
    .divisor  (bit_window_ticks),
    .stat     (div_stat)
  );

  ootx_dfr_frame #(
    .INFO_BLOCK_BYTES (INFO_BLOCK_BYTES)
  ) u_frame (
    .clk        (clk),
    .rst        (rst),
    .ctl        (frame_ctl),
    .wr         (buf_wr),
    .emit       (emit),
    .block_done (block_done)
  );

  ootx_dfr_ram #(
    .DEPTH (INFO_BLOCK_BYTES)
  ) u_ram (
    .clk     (clk),
    .wr      (buf_wr),
    .rd_en   (rd_en),
    .rd_addr (idx[AW-1:0]),
    .rdata   (rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (div_start) state_next = ST_DIV;
      ST_DIV: begin
        if (div_stat.done) state_next = emit ? ST_READ : ST_IDLE;
      end
      ST_READ: state_next = ST_SHOW;
      ST_SHOW: begin
        if (m_tready) state_next = m_tlast ? ST_IDLE : ST_READ;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    m_tvalid = (state == ST_SHOW);
    rd_en    = (state == ST_READ);
    m_tlast  = (idx == LAST_IDX);
    m_tdata  = {2'b00, rdata, idx};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (emit) begin
        idx <= '0;
      end else if (m_acc) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input accepted while a burst byte is pending");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[5:0] == LAST_IDX))
    else $error("tlast on a byte other than the final one");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    block_done |=> block_done)
    else $error("block done flag dropped without reset");

  a_burst_after_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> block_done)
    else $error("burst byte shown before the block was complete");

endmodule
